// File: sv/arp_static_next_hop_resolver_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the static next-hop resolver
// Each macro expands to a labeled concurrent assertion, or to nothing when
// assertions are switched off for a build.
// ----------------------------------------------------------------------------
`ifndef ARP_STATIC_NEXT_HOP_RESOLVER_CORE_ASSERT_SVH
`define ARP_STATIC_NEXT_HOP_RESOLVER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define ANHR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("anhr assertion failed");
// Next-cycle implication, checked out of reset.
`define ANHR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("anhr assertion failed");
`else
`define ANHR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ANHR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: sv/anhr_pkg.sv
// ----------------------------------------------------------------------------
// anhr_pkg
// Shared types and constants of the static next-hop resolver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package anhr_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOCAL_IP    = 2'd0;
  localparam logic [1:0] CFG_SUBNET_MASK = 2'd1;
  localparam logic [1:0] CFG_GATEWAY_IP  = 2'd2;

  // Result status codes.
  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_BAD     = 3'd1;
  localparam logic [2:0] STS_DUP     = 3'd2;
  localparam logic [2:0] STS_FULL    = 3'd3;
  localparam logic [2:0] STS_NOROUTE = 3'd4;

  // Request kinds.
  localparam logic MODE_ADD     = 1'b0;
  localparam logic MODE_RESOLVE = 1'b1;

  // Outcome of classifying one request.
  typedef struct packed {
    logic        is_add;
    logic        need_scan;   // table lookup required
    logic [2:0]  status;      // immediate status when no lookup
    logic [47:0] dmac;        // immediate MAC when no lookup
    logic        via;         // gateway replaced the destination
    logic [31:0] target;      // address to look up or store
    logic [47:0] mac;         // MAC to store on add
  } cls_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] dest_mac;
    logic [3:0]  slot_index;
    logic        via_gateway;
  } res_t;

endpackage

// File: sv/anhr_ram.sv
// ----------------------------------------------------------------------------
// anhr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module anhr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/anhr_classify.sv
// ----------------------------------------------------------------------------
// anhr_classify
// Sorts an accepted request into an immediate answer or a table lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module anhr_classify (
  input  logic          clk,
  input  logic          load_i,
  input  logic          mode_i,
  input  logic [31:0]   ip_i,
  input  logic [47:0]   mac_i,
  input  logic [31:0]   local_ip_i,
  input  logic [31:0]   mask_i,
  input  logic [31:0]   gateway_i,
  output anhr_pkg::cls_t cls_o
);
  import anhr_pkg::*;

  cls_t cls_nxt;
  logic same_sub;
  logic bcast;
  logic mcast;
  logic link_local;

  always_comb begin
    same_sub   = (ip_i & mask_i) == (local_ip_i & mask_i);
    mcast      = ip_i[31:28] == 4'hE;
    link_local = ip_i[31:16] == 16'hA9FE;
    // All ones and zero are always broadcast; otherwise only a subnet address
    // with every host bit set that is not our own address.
    bcast = (ip_i == 32'hFFFF_FFFF) || (ip_i == 32'h0) ||
            ((ip_i != local_ip_i) && same_sub && ((ip_i | mask_i) == 32'hFFFF_FFFF));

    cls_nxt.is_add    = (mode_i == MODE_ADD);
    cls_nxt.need_scan = 1'b0;
    cls_nxt.status    = STS_OK;
    cls_nxt.dmac      = 48'h0;
    cls_nxt.via       = 1'b0;
    cls_nxt.target    = ip_i;
    cls_nxt.mac       = mac_i;

    if (mode_i == MODE_ADD) begin
      if (bcast || mcast) begin
        cls_nxt.status = STS_BAD;
      end else begin
        cls_nxt.need_scan = 1'b1;
      end
    end else begin
      priority if (bcast) begin
        cls_nxt.dmac = 48'hFFFF_FFFF_FFFF;
      end else if (mcast) begin
        cls_nxt.dmac = {24'h01005E, 1'b0, ip_i[22:0]};
      end else if (!same_sub && !link_local) begin
        if (gateway_i != 32'h0) begin
          cls_nxt.need_scan = 1'b1;
          cls_nxt.target    = gateway_i;
          cls_nxt.via       = 1'b1;
        end else begin
          cls_nxt.status = STS_NOROUTE;
        end
      end else begin
        cls_nxt.need_scan = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      cls_o <= cls_nxt;
    end
  end

endmodule

// File: sv/anhr_ctrl.sv
// ----------------------------------------------------------------------------
// anhr_ctrl
// Sequencer that scans the slot memories, adds entries and builds results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "arp_static_next_hop_resolver_core_assert.svh"

module anhr_ctrl #(
  parameter int unsigned TABLE_SLOTS = anhr_pkg::TABLE_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start_i,
  input  anhr_pkg::cls_t cls_i,
  output logic           idle_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output anhr_pkg::res_t res_o
);
  import anhr_pkg::*;

  localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);
  localparam logic [CW-1:0] SCAN_END = CW'(TABLE_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLASS = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          scan_cnt_r, scan_cnt_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]          chk_idx_r, chk_idx_nxt;
  logic                   empty_fnd_r, empty_fnd_nxt;
  logic [IW-1:0]          empty_idx_r, empty_idx_nxt;
  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  res_t                   res_r, res_nxt;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [31:0]   rd_ip;
  logic [47:0]   rd_mac;
  logic          hit;
  logic          cur_empty;

  anhr_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS), .AW(IW)) u_ip_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (cls_i.target),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_ip)
  );

  anhr_ram #(.WIDTH(48), .DEPTH(TABLE_SLOTS), .AW(IW)) u_mac_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (cls_i.mac),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_mac)
  );

  // Reads are issued one slot per cycle; the compare stage sees the data of
  // the slot issued in the previous cycle.
  always_comb begin
    state_nxt     = state_r;
    scan_cnt_nxt  = scan_cnt_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    empty_fnd_nxt = empty_fnd_r;
    empty_idx_nxt = empty_idx_r;
    valid_nxt     = valid_r;
    res_nxt       = res_r;
    rd_en         = 1'b0;
    rd_addr       = scan_cnt_r[IW-1:0];
    wr_en         = 1'b0;
    wr_idx        = empty_fnd_r ? empty_idx_r : chk_idx_r;
    hit           = chk_vld_r && valid_r[chk_idx_r] && (rd_ip == cls_i.target);
    cur_empty     = chk_vld_r && !valid_r[chk_idx_r];

    unique case (state_r)
      S_IDLE: begin
        if (start_i) begin
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        scan_cnt_nxt  = '0;
        chk_vld_nxt   = 1'b0;
        empty_fnd_nxt = 1'b0;
        if (cls_i.need_scan) begin
          state_nxt = S_SCAN;
        end else begin
          res_nxt.status      = cls_i.status;
          res_nxt.dest_mac    = cls_i.dmac;
          res_nxt.slot_index  = 4'h0;
          res_nxt.via_gateway = cls_i.via;
          state_nxt           = S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_cnt_r != SCAN_END) begin
          rd_en        = 1'b1;
          scan_cnt_nxt = scan_cnt_r + 1'b1;
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = scan_cnt_r[IW-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (cur_empty && !empty_fnd_r) begin
          empty_fnd_nxt = 1'b1;
          empty_idx_nxt = chk_idx_r;
        end
        res_nxt.via_gateway = cls_i.via;
        res_nxt.dest_mac    = 48'h0;
        res_nxt.slot_index  = 4'h0;
        if (hit) begin
          chk_vld_nxt        = 1'b0;
          res_nxt.slot_index = 4'(chk_idx_r);
          if (cls_i.is_add) begin
            res_nxt.status = STS_DUP;
          end else begin
            res_nxt.status   = STS_OK;
            res_nxt.dest_mac = rd_mac;
          end
          state_nxt = S_DONE;
        end else if (chk_vld_r && (chk_idx_r == LAST_IDX)) begin
          chk_vld_nxt = 1'b0;
          if (!cls_i.is_add) begin
            res_nxt.status = STS_NOROUTE;
          end else if (empty_fnd_r || cur_empty) begin
            wr_en              = 1'b1;
            valid_nxt[wr_idx]  = 1'b1;
            res_nxt.status     = STS_OK;
            res_nxt.slot_index = 4'(wr_idx);
          end else begin
            res_nxt.status = STS_FULL;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_cnt_r  <= '0;
      chk_vld_r   <= 1'b0;
      empty_fnd_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      empty_fnd_r <= empty_fnd_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r   <= chk_idx_nxt;
    empty_idx_r <= empty_idx_nxt;
    res_r       <= res_nxt;
  end

  assign idle_o      = (state_r == S_IDLE);
  assign res_valid_o = (state_r == S_DONE);
  assign res_o       = res_r;

  `ANHR_ASSERT_IMP(a_write_free_slot, clk, rst_n, wr_en, !valid_r[wr_idx])
  `ANHR_ASSERT_NXT(a_fill_grows, clk, rst_n, wr_en, $countones(valid_r) == $past($countones(valid_r)) + 1)
  `ANHR_ASSERT_IMP(a_full_means_full, clk, rst_n, res_valid_o && (res_r.status == STS_FULL), &valid_r)
  `ANHR_ASSERT_IMP(a_check_in_scan, clk, rst_n, chk_vld_r, state_r == S_SCAN)

endmodule

// File: sv/arp_static_next_hop_resolver_core.sv
// ----------------------------------------------------------------------------
// arp_static_next_hop_resolver_core
// Static IPv4-to-MAC table with add and resolve requests for one interface.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. Broadcast, multicast, rejected and
// unroutable requests are answered without a table lookup and pass from the
// classify register through the result register into the output register.
// Requests that need the table scan the slot memories one slot per cycle
// through their single read port, and the scan stops early when a match is
// found. The next request can be taken from the cycle after a result moves
// into the output register. The next request is taken while a finished
// result still waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arp_static_next_hop_resolver_core #(
  parameter int unsigned TABLE_SLOTS = anhr_pkg::TABLE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Request stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // [31:0] ip_address, [79:32] mac_address
  input  logic        in_tuser,   // [0] mode
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [2:0] status, [50:3] dest_mac,
                                  // [54:51] slot_index, [55] via_gateway
);
  import anhr_pkg::*;

  logic [31:0] local_ip_r;
  logic [31:0] subnet_mask_r;
  logic [31:0] gateway_ip_r;
  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r;

  cls_t cls;
  res_t res;
  logic idle;
  logic res_valid;
  logic res_ready;
  logic in_xfer;
  logic out_load;

  assign cfg_ready = 1'b1;
  assign in_tready = idle;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r    <= 32'h0;
      subnet_mask_r <= 32'h0;
      gateway_ip_r  <= 32'h0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOCAL_IP:    local_ip_r    <= cfg_data;
        CFG_SUBNET_MASK: subnet_mask_r <= cfg_data;
        CFG_GATEWAY_IP:  gateway_ip_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  anhr_classify u_classify (
    .clk        (clk),
    .load_i     (in_xfer),
    .mode_i     (in_tuser),
    .ip_i       (in_tdata[31:0]),
    .mac_i      (in_tdata[79:32]),
    .local_ip_i (local_ip_r),
    .mask_i     (subnet_mask_r),
    .gateway_i  (gateway_ip_r),
    .cls_o      (cls)
  );

  anhr_ctrl #(.TABLE_SLOTS(TABLE_SLOTS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (in_xfer),
    .cls_i       (cls),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: filled when empty or emptied in the same cycle.
  assign res_ready = !out_valid_r || out_tready;
  assign out_load  = res_valid && res_ready;

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.via_gateway, out_res_r.slot_index,
                       out_res_r.dest_mac, out_res_r.status};

endmodule

// File: verif/tb_arp_static_next_hop_resolver_core.sv
// ----------------------------------------------------------------------------
// tb_arp_static_next_hop_resolver_core
// Self-checking bench for the static next-hop resolver. Add and resolve
// requests are streamed in under several interface settings. Each accepted
// request is run through a local model of the table and the address rules,
// and every result transfer is checked field by field against it. Both stream
// sides idle at random, and once the result side holds off long enough to
// back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_arp_static_next_hop_resolver_core;
  import anhr_pkg::*;

  localparam int SLOT_COUNT     = TABLE_SLOTS_DEF;
  localparam int POOL_SIZE      = 24;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic        mode;
    logic [31:0] ip;
    logic [47:0] mac;
  } nh_req_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  // Model of the interface settings and the static table.
  logic [31:0] cur_local;
  logic [31:0] cur_mask;
  logic [31:0] cur_gw;
  logic        tbl_valid [SLOT_COUNT];
  logic [31:0] tbl_ip    [SLOT_COUNT];
  logic [47:0] tbl_mac   [SLOT_COUNT];

  nh_req_t     request_fifo[$];
  res_t        pending_results[$];
  logic [31:0] addr_pool [POOL_SIZE];

  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  logic        no_idle   = 1'b0;
  int          gap_cnt   = 0;
  int          stall_cnt = 0;
  int          hold_cnt  = 0;
  int          press_req  = 0;
  int          press_seen = 0;
  int          idle_cycles = 0;
  int          err_count  = 0;
  int          result_count = 0;

  arp_static_next_hop_resolver_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic is_mcast(input logic [31:0] a);
    return a[31:28] == 4'he;
  endfunction

  function automatic logic is_llocal(input logic [31:0] a);
    return a[31:16] == 16'ha9fe;
  endfunction

  function automatic logic on_subnet(input logic [31:0] a);
    return (a & cur_mask) == (cur_local & cur_mask);
  endfunction

  // Zero counts as broadcast too, so it covers the zero-address add check.
  function automatic logic is_bcast(input logic [31:0] a);
    if (a == 32'hffff_ffff || a == 32'h0) return 1'b1;
    if (a == cur_local) return 1'b0;
    return on_subnet(a) && ((a & ~cur_mask) == ~cur_mask);
  endfunction

  function automatic int find_slot(input logic [31:0] a);
    for (int k = 0; k < SLOT_COUNT; k++)
      if (tbl_valid[k] && tbl_ip[k] == a) return k;
    return SLOT_COUNT;
  endfunction

  // Applies one request to the table model and returns the result it gives.
  function automatic res_t resolve_next_hop(input logic mode, input logic [31:0] ip,
                                            input logic [47:0] mac);
    res_t        r;
    int          k;
    logic [31:0] target;
    logic        routed;
    r = '0;
    r.status = STS_OK;
    if (mode == MODE_ADD) begin
      if (is_bcast(ip) || is_mcast(ip)) begin
        r.status = STS_BAD;
      end else begin
        k = find_slot(ip);
        if (k < SLOT_COUNT) begin
          r.status = STS_DUP;
          r.slot_index = 4'(k);
        end else begin
          k = 0;
          while (k < SLOT_COUNT && tbl_valid[k]) k++;
          if (k >= SLOT_COUNT) begin
            r.status = STS_FULL;
          end else begin
            tbl_valid[k] = 1'b1;
            tbl_ip[k] = ip;
            tbl_mac[k] = mac;
            r.slot_index = 4'(k);
          end
        end
      end
    end else if (is_bcast(ip)) begin
      r.dest_mac = '1;
    end else if (is_mcast(ip)) begin
      r.dest_mac = {24'h01005e, 1'b0, ip[22:0]};
    end else begin
      target = ip;
      routed = 1'b1;
      if (!on_subnet(ip) && !is_llocal(ip)) begin
        if (cur_gw != 32'h0) begin
          target = cur_gw;
          r.via_gateway = 1'b1;
        end else begin
          routed = 1'b0;
        end
      end
      k = routed ? find_slot(target) : SLOT_COUNT;
      if (k < SLOT_COUNT) begin
        r.dest_mac = tbl_mac[k];
        r.slot_index = 4'(k);
      end else begin
        r.status = STS_NOROUTE;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic int draw_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 16);
    return 0;
  endfunction

  // Pool addresses most often, so that the table fills and lookups hit, with
  // every address class mixed in and some fully random addresses.
  function automatic logic [31:0] pick_ip();
    logic [31:0] a;
    int unsigned r;
    r = $urandom_range(0, 99);
    a = $urandom();
    if (r < 45)      a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (r < 55) a = (cur_local & cur_mask) | (a & ~cur_mask);
    else if (r < 62) a = {4'he, a[27:0]};
    else if (r < 67) a = {16'ha9fe, a[15:0]};
    else if (r < 70) a = 32'hffff_ffff;
    else if (r < 73) a = 32'h0;
    else if (r < 76) a = cur_local | ~cur_mask;
    else if (r < 78) a = cur_local;
    return a;
  endfunction

  task automatic push_req(input logic mode, input logic [31:0] ip, input logic [47:0] mac);
    nh_req_t q;
    q.mode = mode;
    q.ip = ip;
    q.mac = mac;
    request_fifo.push_back(q);
  endtask

  task automatic add_random(input int n);
    repeat (n) begin
      push_req(($urandom_range(0, 99) < 35) ? MODE_ADD : MODE_RESOLVE, pick_ip(),
               {16'($urandom_range(0, 16'hffff)), 32'($urandom())});
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_interface(input logic [31:0] lip, input logic [31:0] mask,
                               input logic [31:0] gw);
    write_reg(CFG_LOCAL_IP, lip);
    write_reg(CFG_SUBNET_MASK, mask);
    write_reg(CFG_GATEWAY_IP, gw);
  endtask

  // Waits until every request has gone in and every result has come back,
  // then lets the block settle before anything else is written.
  task automatic drain();
    do @(posedge clk);
    while (request_fifo.size() != 0 || in_tvalid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Request driver.
  always @(negedge clk) begin : req_drive
    nh_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (gap_cnt > 0) begin
        gap_cnt--;
        in_tvalid <= 1'b0;
      end else if (request_fifo.size() > 0) begin
        nxt = request_fifo.pop_front();
        in_tdata  <= {nxt.mac, nxt.ip};
        in_tuser  <= nxt.mode;
        in_tvalid <= 1'b1;
        gap_cnt = draw_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result-side pacing, including the long hold-off that backs the block up.
  always @(negedge clk) begin : res_pace
    if (press_req != press_seen) begin
      press_seen = press_req;
      hold_cnt = HOLD_CYCLES;
    end
    if (out_taken) stall_cnt = draw_gap();
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor, checker and watchdog.
  always @(posedge clk) begin : observe
    res_t got;
    res_t want;
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken  <= in_tvalid && in_tready;
      out_taken <= out_tvalid && out_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOCAL_IP:    cur_local = cfg_data;
          CFG_SUBNET_MASK: cur_mask  = cfg_data;
          CFG_GATEWAY_IP:  cur_gw    = cfg_data;
          default: ;
        endcase
      end
      // A result always belongs to an earlier request, so check before predicting.
      if (out_tvalid && out_tready) begin
        result_count++;
        got.status      = out_tdata[2:0];
        got.dest_mac    = out_tdata[50:3];
        got.slot_index  = out_tdata[54:51];
        got.via_gateway = out_tdata[55];
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    result_count));
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      result_count, got.status, want.status));
          if (got.dest_mac !== want.dest_mac)
            report_mismatch($sformatf("result %0d dest_mac %h, expected %h",
                                      result_count, got.dest_mac, want.dest_mac));
          if (got.slot_index !== want.slot_index)
            report_mismatch($sformatf("result %0d slot_index %0d, expected %0d",
                                      result_count, got.slot_index, want.slot_index));
          if (got.via_gateway !== want.via_gateway)
            report_mismatch($sformatf("result %0d via_gateway %b, expected %b",
                                      result_count, got.via_gateway, want.via_gateway));
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(resolve_next_hop(in_tuser, in_tdata[31:0],
                                                   in_tdata[79:32]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles", $realtime, idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] mask;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LOCAL_IP;
    cfg_data  = '0;
    cur_local = '0;
    cur_mask  = '0;
    cur_gw    = '0;
    foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < 10)      addr_pool[i] = {24'hc0a801, 8'(1 + 3 * i)};
      else if (i < 16) addr_pool[i] = {16'h0a00, 8'(i), 8'(7 * i)};
      else if (i < 19) addr_pool[i] = {16'ha9fe, 8'(i), 8'(i)};
      else             addr_pool[i] = $urandom();
    end
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Class /24 interface with a gateway that gets added to the table.
    set_interface(32'hc0a8_010a, 32'hffff_ff00, 32'hc0a8_0101);
    push_req(MODE_RESOLVE, 32'h0000_0000, 48'h0);
    push_req(MODE_RESOLVE, 32'hffff_ffff, 48'hffff_ffff_ffff);
    push_req(MODE_RESOLVE, 32'hc0a8_01ff, 48'h0);
    push_req(MODE_RESOLVE, 32'he000_0001, 48'h0);
    push_req(MODE_RESOLVE, 32'hefff_ffff, 48'hffff_ffff_ffff);
    push_req(MODE_RESOLVE, 32'hc0a8_0114, 48'h0);
    push_req(MODE_RESOLVE, 32'h0808_0808, 48'h0);
    push_req(MODE_ADD,     32'h0000_0000, 48'h0000_0000_0001);
    push_req(MODE_ADD,     32'hffff_ffff, 48'h0000_0000_0002);
    push_req(MODE_ADD,     32'hc0a8_01ff, 48'h0000_0000_0003);
    push_req(MODE_ADD,     32'he000_0001, 48'h0000_0000_0004);
    push_req(MODE_ADD,     32'hc0a8_0101, 48'h0000_0000_0000);
    push_req(MODE_ADD,     32'hc0a8_0114, 48'hffff_ffff_ffff);
    push_req(MODE_ADD,     32'hc0a8_0114, 48'h1234_5678_9abc);
    push_req(MODE_ADD,     32'hc0a8_010a, 48'h0a0b_0c0d_0e0f);
    push_req(MODE_RESOLVE, 32'hc0a8_0114, 48'h0);
    push_req(MODE_RESOLVE, 32'h0808_0808, 48'h0);
    push_req(MODE_RESOLVE, 32'ha9fe_0304, 48'h0);
    push_req(MODE_ADD,     32'ha9fe_0304, 48'haaaa_aaaa_aaaa);
    push_req(MODE_RESOLVE, 32'ha9fe_0304, 48'h0);
    push_req(MODE_RESOLVE, 32'hc0a8_010a, 48'h0);
    push_req(MODE_ADD,     32'h7fff_ffff, 48'h5555_5555_5555);
    add_random(230);
    drain();

    // No gateway: off-subnet destinations have no route. The result side
    // stalls for a long stretch while requests keep coming.
    set_interface(32'h0a00_0005, 32'hffff_0000, 32'h0000_0000);
    push_req(MODE_RESOLVE, 32'h0808_0808, 48'h0);
    add_random(200);
    press_req++;
    drain();

    // Everything on subnet, all-ones gateway, no idling on either side.
    no_idle = 1'b1;
    set_interface(32'h0000_0000, 32'h0000_0000, 32'hffff_ffff);
    add_random(200);
    drain();
    no_idle = 1'b0;

    // Host mask: every other unicast address that is not link-local leaves through the gateway.
    set_interface(32'hffff_ffff, 32'hffff_ffff, addr_pool[0]);
    add_random(200);
    drain();

    mask = ~(32'hffff_ffff >> $urandom_range(0, 32));
    set_interface($urandom(), mask, addr_pool[$urandom_range(0, 9)]);
    add_random(200);
    drain();

    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/anhr_pkg.sv
sv/anhr_ram.sv
sv/anhr_classify.sv
sv/anhr_ctrl.sv
sv/arp_static_next_hop_resolver_core.sv
verif/tb_arp_static_next_hop_resolver_core.sv
